// ----- hw/rtl/tohlc_pkg.sv -----
// shared widths, state codes and the result beat type of the ohlc bar aggregator
package tohlc_pkg;

  localparam int INST_W  = 6;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int PRICE_W = 32;

  localparam int BAR_FIFO_DEPTH = 4;
  localparam int BAR_PTR_W      = 2;
  localparam int BAR_CNT_W      = 3;

  localparam logic BAR_MINUTE = 1'b0;
  localparam logic BAR_HOUR   = 1'b1;

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } seq_state_t;

  typedef struct packed {
    logic               kind;
    logic [INST_W-1:0]  instrument;
    logic [HOUR_W-1:0]  hour;
    logic [MIN_W-1:0]   minute;
    logic [PRICE_W-1:0] open_price;
    logic [PRICE_W-1:0] high_price;
    logic [PRICE_W-1:0] low_price;
    logic [PRICE_W-1:0] close_price;
    logic               last_of_run;
  } bar_t;

  typedef struct packed {
    logic first;
    logic second;
  } bar_push_t;

endpackage

// ----- hw/rtl/tohlc_bar_fifo.sv -----
// result queue that takes up to two bars per cycle and hands out one beat at a time
module tohlc_bar_fifo
  import tohlc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  bar_push_t push,
  input  bar_t      bar0,
  input  bar_t      bar1,
  output logic      room,
  output logic      out_valid,
  input  logic      out_stall,
  output bar_t      out_bar
);

  bar_t                 mem [BAR_FIFO_DEPTH];
  logic [BAR_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [BAR_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [BAR_CNT_W-1:0] count_r, count_nxt;
  logic [BAR_PTR_W-1:0] wr_ptr_p1;
  logic                 pop;
  logic [BAR_CNT_W-1:0] push_n;

  assign wr_ptr_p1 = wr_ptr_r + BAR_PTR_W'(1);
  assign out_valid = (count_r != '0);
  assign out_bar   = mem[rd_ptr_r];
  assign pop       = out_valid && !out_stall;
  assign room      = (BAR_CNT_W'(BAR_FIFO_DEPTH) - count_r) >= BAR_CNT_W'(2);

  always_comb begin
    push_n     = BAR_CNT_W'(push.first) + BAR_CNT_W'(push.second);
    wr_ptr_nxt = wr_ptr_r + push_n[BAR_PTR_W-1:0];
    rd_ptr_nxt = pop ? rd_ptr_r + BAR_PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + push_n - BAR_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.first) begin
      mem[wr_ptr_r] <= bar0;
    end
    if (push.second) begin
      mem[wr_ptr_p1] <= bar1;
    end
  end

endmodule

// ----- hw/rtl/tick_to_ohlc_bar_aggregator.sv -----
// top level: per-instrument minute and hour ohlc bars built from a tick stream
//
// One tick is taken every cycle while the result queue has room. A tick's bars pass through
// stage one and the result queue before they reach the output; the per-instrument state sits
// in one synchronous memory that is read when the tick is taken and written back from stage
// one, with the last write forwarded when consecutive ticks hit the same instrument. The
// output side moves one bar per cycle, when the receiver does not stall, through a four-entry
// queue, so a run of ticks that each close both a minute and an hour bar is held back by the
// queue. After reset the block takes no tick while it clears every entry of the memory.
module tick_to_ohlc_bar_aggregator
  import tohlc_pkg::*;
#(
  parameter int NUM_INSTRUMENTS = 64,
  parameter int PRICE_BITS      = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [INST_W-1:0]  in_instrument,
  input  logic [HOUR_W-1:0]  in_tick_hour,
  input  logic [MIN_W-1:0]   in_tick_minute,
  input  logic [PRICE_W-1:0] in_tick_price,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_bar_kind,
  output logic [INST_W-1:0]  out_bar_instrument,
  output logic [HOUR_W-1:0]  out_bar_hour,
  output logic [MIN_W-1:0]   out_bar_minute,
  output logic [PRICE_W-1:0] out_open_price,
  output logic [PRICE_W-1:0] out_high_price,
  output logic [PRICE_W-1:0] out_low_price,
  output logic [PRICE_W-1:0] out_close_price,
  output logic               out_last_of_run
);

  localparam int AW = (NUM_INSTRUMENTS > 1) ? $clog2(NUM_INSTRUMENTS) : 1;
  localparam int IW = (AW > INST_W) ? AW : INST_W;
  localparam int PW = (PRICE_BITS < PRICE_W) ? PRICE_BITS : PRICE_W;

  typedef struct packed {
    logic              seen;
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [PW-1:0]     close;
    logic [PW-1:0]     m_open;
    logic [PW-1:0]     m_high;
    logic [PW-1:0]     m_low;
    logic [PW-1:0]     h_open;
    logic [PW-1:0]     h_high;
    logic [PW-1:0]     h_low;
  } entry_t;

  seq_state_t state_r, state_nxt;
  logic [AW-1:0] clr_addr_r, clr_addr_nxt;
  logic          clearing;

  entry_t        mem [NUM_INSTRUMENTS];
  entry_t        rdata_r;
  entry_t        fwd_data_r;
  logic          fwd_hit_r;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;

  logic [IW-1:0] in_inst_ext;
  logic [AW-1:0] in_addr;
  logic          in_accept;

  logic              s1_valid_r;
  logic              s1_inrange_r;
  logic [INST_W-1:0] s1_inst_r;
  logic [AW-1:0]     s1_addr_r;
  logic [HOUR_W-1:0] s1_hour_r;
  logic [MIN_W-1:0]  s1_min_r;
  logic [PW-1:0]     s1_price_r;
  logic              s1_fire;

  entry_t    cur;
  entry_t    upd;
  logic      emit_m, emit_h, new_hour, new_min;
  bar_t      bar_m, bar_h, bar0, bar1;
  bar_push_t push;
  logic      fifo_room;
  bar_t      head;

  // clearing sequencer
  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    unique case (state_r)
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(NUM_INSTRUMENTS - 1)) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        state_nxt = ST_RUN;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    unique case (state_r)
      ST_CLEAR: clearing = 1'b1;
      ST_RUN:   clearing = 1'b0;
      default:  clearing = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  // input beat and stage one control
  assign in_inst_ext = IW'(in_instrument);
  assign in_addr     = in_inst_ext[AW-1:0];
  assign s1_fire     = s1_valid_r && fifo_room && !clearing;
  assign in_stall    = clearing || (s1_valid_r && !s1_fire);
  assign in_accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_inrange_r <= (32'(in_instrument) < NUM_INSTRUMENTS);
      s1_inst_r    <= in_instrument;
      s1_addr_r    <= in_addr;
      s1_hour_r    <= in_tick_hour;
      s1_min_r     <= in_tick_minute;
      s1_price_r   <= in_tick_price[PW-1:0];
    end
  end

  // state memory, read on the input beat, written back from stage one
  assign wr_en   = clearing || (s1_fire && s1_inrange_r);
  assign wr_addr = clearing ? clr_addr_r : s1_addr_r;
  assign wr_data = clearing ? entry_t'('0) : upd;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (in_accept) begin
      rdata_r <= mem[in_addr];
    end
  end

  // same-edge write to the entry being read is not seen by the read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_hit_r <= 1'b0;
    end else if (in_accept) begin
      fwd_hit_r <= wr_en && (wr_addr == in_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      fwd_data_r <= wr_data;
    end
  end

  // bar update
  always_comb begin
    cur      = fwd_hit_r ? fwd_data_r : rdata_r;
    emit_m   = cur.seen && (cur.minute != s1_min_r);
    emit_h   = cur.seen && (cur.hour != s1_hour_r);
    new_hour = !cur.seen || emit_h;
    new_min  = new_hour || emit_m;

    upd        = cur;
    upd.seen   = 1'b1;
    upd.hour   = s1_hour_r;
    upd.minute = s1_min_r;
    upd.close  = s1_price_r;
    if (new_hour) begin
      upd.h_open = s1_price_r;
      upd.h_high = s1_price_r;
      upd.h_low  = s1_price_r;
    end else begin
      if (s1_price_r > cur.h_high) upd.h_high = s1_price_r;
      if (s1_price_r < cur.h_low)  upd.h_low  = s1_price_r;
    end
    if (new_min) begin
      upd.m_open = s1_price_r;
      upd.m_high = s1_price_r;
      upd.m_low  = s1_price_r;
    end else begin
      if (s1_price_r > cur.m_high) upd.m_high = s1_price_r;
      if (s1_price_r < cur.m_low)  upd.m_low  = s1_price_r;
    end
  end

  always_comb begin
    bar_m.kind        = BAR_MINUTE;
    bar_m.instrument  = s1_inst_r;
    bar_m.hour        = cur.hour;
    bar_m.minute      = cur.minute;
    bar_m.open_price  = PRICE_W'(cur.m_open);
    bar_m.high_price  = PRICE_W'(cur.m_high);
    bar_m.low_price   = PRICE_W'(cur.m_low);
    bar_m.close_price = PRICE_W'(cur.close);
    bar_m.last_of_run = !emit_h;

    bar_h.kind        = BAR_HOUR;
    bar_h.instrument  = s1_inst_r;
    bar_h.hour        = cur.hour;
    bar_h.minute      = '0;
    bar_h.open_price  = PRICE_W'(cur.h_open);
    bar_h.high_price  = PRICE_W'(cur.h_high);
    bar_h.low_price   = PRICE_W'(cur.h_low);
    bar_h.close_price = PRICE_W'(cur.close);
    bar_h.last_of_run = 1'b1;

    bar0        = emit_m ? bar_m : bar_h;
    bar1        = bar_h;
    push.first  = s1_fire && s1_inrange_r && (emit_m || emit_h);
    push.second = s1_fire && s1_inrange_r && emit_m && emit_h;
  end

  tohlc_bar_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .bar0      (bar0),
    .bar1      (bar1),
    .room      (fifo_room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_bar   (head)
  );

  assign out_bar_kind       = head.kind;
  assign out_bar_instrument = head.instrument;
  assign out_bar_hour       = head.hour;
  assign out_bar_minute     = head.minute;
  assign out_open_price     = head.open_price;
  assign out_high_price     = head.high_price;
  assign out_low_price      = head.low_price;
  assign out_close_price    = head.close_price;
  assign out_last_of_run    = head.last_of_run;

  // checks
  a_no_beat_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> in_stall)
    else $error("input beat open during memory clear");

  a_writeback_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && !clearing) |-> (s1_valid_r && fifo_room && s1_inrange_r))
    else $error("state written back without a live tick or queue room");

  a_forward_on_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && wr_en && (wr_addr == in_addr)) |=> fwd_hit_r)
    else $error("back-to-back tick on one instrument missed forwarding");

  a_second_bar_is_hour: assert property (@(posedge clk) disable iff (!rst_n)
    push.second |-> (push.first && bar0.kind == BAR_MINUTE && !bar0.last_of_run))
    else $error("two bars pushed out of order");

endmodule

// ----- verif/tb.sv -----
// self-checking testbench for the tick to ohlc bar aggregator
module tb;
  import tohlc_pkg::*;

  localparam int N_INST = 1 << INST_W;

  class ohlc_book;
    bit                 seen [N_INST];
    logic [HOUR_W-1:0]  last_hour [N_INST];
    logic [MIN_W-1:0]   last_minute [N_INST];
    logic [PRICE_W-1:0] last_price [N_INST];
    logic [PRICE_W-1:0] min_open [N_INST];
    logic [PRICE_W-1:0] min_high [N_INST];
    logic [PRICE_W-1:0] min_low [N_INST];
    logic [PRICE_W-1:0] hr_open [N_INST];
    logic [PRICE_W-1:0] hr_high [N_INST];
    logic [PRICE_W-1:0] hr_low [N_INST];
    bar_t               due_bars [$];
    int                 errors;
    int                 ticks_taken;
    int                 minute_bars;
    int                 hour_bars;

    function new();
      foreach (seen[i]) seen[i] = 1'b0;
      errors = 0;
      ticks_taken = 0;
      minute_bars = 0;
      hour_bars = 0;
    endfunction

    function void take_tick(logic [INST_W-1:0] inst, logic [HOUR_W-1:0] hr,
                            logic [MIN_W-1:0] mn, logic [PRICE_W-1:0] p);
      bar_t b;
      bit   hour_turn;
      bit   minute_turn;
      ticks_taken++;
      if (!seen[inst]) begin
        seen[inst] = 1'b1;
        hour_turn = 1'b1;
        minute_turn = 1'b1;
      end else begin
        hour_turn = last_hour[inst] != hr;
        minute_turn = last_minute[inst] != mn;
        b.instrument = inst;
        b.hour = last_hour[inst];
        b.close_price = last_price[inst];
        if (minute_turn) begin
          b.kind = BAR_MINUTE;
          b.minute = last_minute[inst];
          b.open_price = min_open[inst];
          b.high_price = min_high[inst];
          b.low_price = min_low[inst];
          b.last_of_run = !hour_turn;
          due_bars.push_back(b);
        end
        if (hour_turn) begin
          b.kind = BAR_HOUR;
          b.minute = '0;
          b.open_price = hr_open[inst];
          b.high_price = hr_high[inst];
          b.low_price = hr_low[inst];
          b.last_of_run = 1'b1;
          due_bars.push_back(b);
        end
      end
      if (hour_turn) begin
        hr_open[inst] = p;
        hr_high[inst] = p;
        hr_low[inst] = p;
      end else begin
        if (p > hr_high[inst]) hr_high[inst] = p;
        if (p < hr_low[inst]) hr_low[inst] = p;
      end
      if (hour_turn || minute_turn) begin
        min_open[inst] = p;
        min_high[inst] = p;
        min_low[inst] = p;
      end else begin
        if (p > min_high[inst]) min_high[inst] = p;
        if (p < min_low[inst]) min_low[inst] = p;
      end
      last_hour[inst] = hr;
      last_minute[inst] = mn;
      last_price[inst] = p;
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void match_bar(bar_t got);
      bar_t want;
      if (due_bars.size() == 0) begin
        $error("bar with no tick behind it: kind %0d instrument %0d", got.kind, got.instrument);
        errors++;
        return;
      end
      want = due_bars.pop_front();
      if (want.kind == BAR_HOUR) hour_bars++;
      else minute_bars++;
      check_field("bar_kind", 32'(want.kind), 32'(got.kind));
      check_field("bar_instrument", 32'(want.instrument), 32'(got.instrument));
      check_field("bar_hour", 32'(want.hour), 32'(got.hour));
      check_field("bar_minute", 32'(want.minute), 32'(got.minute));
      check_field("open_price", want.open_price, got.open_price);
      check_field("high_price", want.high_price, got.high_price);
      check_field("low_price", want.low_price, got.low_price);
      check_field("close_price", want.close_price, got.close_price);
      check_field("last_of_run", 32'(want.last_of_run), 32'(got.last_of_run));
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [INST_W-1:0]  in_instrument = '0;
  logic [HOUR_W-1:0]  in_tick_hour = '0;
  logic [MIN_W-1:0]   in_tick_minute = '0;
  logic [PRICE_W-1:0] in_tick_price = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_bar_kind;
  logic [INST_W-1:0]  out_bar_instrument;
  logic [HOUR_W-1:0]  out_bar_hour;
  logic [MIN_W-1:0]   out_bar_minute;
  logic [PRICE_W-1:0] out_open_price;
  logic [PRICE_W-1:0] out_high_price;
  logic [PRICE_W-1:0] out_low_price;
  logic [PRICE_W-1:0] out_close_price;
  logic               out_last_of_run;

  ohlc_book book;
  bar_t     seen_bar;

  tick_to_ohlc_bar_aggregator uut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        book.take_tick(in_instrument, in_tick_hour, in_tick_minute, in_tick_price);
      if (out_valid && !out_stall) begin
        seen_bar.kind = out_bar_kind;
        seen_bar.instrument = out_bar_instrument;
        seen_bar.hour = out_bar_hour;
        seen_bar.minute = out_bar_minute;
        seen_bar.open_price = out_open_price;
        seen_bar.high_price = out_high_price;
        seen_bar.low_price = out_low_price;
        seen_bar.close_price = out_close_price;
        seen_bar.last_of_run = out_last_of_run;
        book.match_bar(seen_bar);
      end
    end
  end

  task automatic send_tick(logic [INST_W-1:0] inst, logic [HOUR_W-1:0] hr,
                           logic [MIN_W-1:0] mn, logic [PRICE_W-1:0] p);
    in_valid <= 1'b1;
    in_instrument <= inst;
    in_tick_hour <= hr;
    in_tick_minute <= mn;
    in_tick_price <= p;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic pause(int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // receiver: stall modes per stretch, plus one long hold-off to back up the block
  initial begin : receiver
    int  mode;
    int  span;
    int  hold_left;
    bit  held;
    hold_left = 0;
    held = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(5, 60);
      repeat (span) begin
        @(posedge clk);
        if (!held && book != null && book.ticks_taken >= 300) begin
          held = 1'b1;
          hold_left = 400;
        end
        if (hold_left > 0) begin
          hold_left--;
          out_stall <= 1'b1;
        end else begin
          case (mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= ~out_stall;
          endcase
        end
      end
    end
  end

  initial begin : stimulus
    logic [HOUR_W-1:0]  hour_at [N_INST];
    logic [MIN_W-1:0]   minute_at [N_INST];
    logic [PRICE_W-1:0] price_at [N_INST];
    logic [INST_W-1:0]  pool [8];
    logic [INST_W-1:0]  inst;
    int                 burst;
    int                 r;
    int                 drain;
    book = new();
    foreach (hour_at[i]) begin
      hour_at[i] = HOUR_W'($urandom_range(0, 23));
      minute_at[i] = MIN_W'($urandom_range(0, 59));
      price_at[i] = $urandom;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // opening tick, then same-minute extremes
    send_tick(0, 0, 0, 32'h0);
    send_tick(0, 0, 0, 32'hFFFF_FFFF);
    send_tick(0, 0, 0, 32'h5);
    // minute change, hour-only change, both at once
    send_tick(0, 0, 1, 32'd100);
    send_tick(0, 1, 1, 32'd200);
    send_tick(0, 2, 2, 32'd50);
    // out-of-range time stamps on the top instrument
    send_tick(63, 31, 63, 32'hFFFF_FFFF);
    send_tick(63, 31, 0, 32'h0);
    send_tick(63, 0, 63, 32'h7);
    // time going backwards
    send_tick(0, 2, 1, 32'd60);
    send_tick(0, 2, 2, 32'd70);
    // alternating bit patterns
    send_tick(42, 10, 42, 32'hAAAA_AAAA);
    send_tick(21, 21, 21, 32'h5555_5555);
    send_tick(42, 10, 42, 32'h5555_5555);
    send_tick(21, 21, 21, 32'hAAAA_AAAA);
    send_tick(42, 21, 21, 32'h0);
    send_tick(21, 10, 42, 32'hFFFF_FFFF);
    send_tick(0, 23, 59, 32'h1);
    send_tick(0, 23, 59, 32'h1);

    inst = '0;
    burst = 0;
    for (int k = 0; k < 900; k++) begin
      if (k % 150 == 0)
        foreach (pool[j]) pool[j] = INST_W'($urandom_range(0, N_INST - 1));
      if (burst == 0) begin
        burst = $urandom_range(1, 40);
        if ($urandom_range(0, 2) != 0) pause($urandom_range(1, 12));
      end
      burst--;
      r = $urandom_range(0, 99);
      if (r < 5) inst = INST_W'($urandom_range(0, N_INST - 1));
      else if (r >= 25) inst = pool[3'($urandom_range(0, 7))];
      r = $urandom_range(0, 99);
      if (r < 55) begin
      end else if (r < 80) begin
        if (minute_at[inst] >= 59) begin
          minute_at[inst] = 0;
          hour_at[inst] = (hour_at[inst] >= 23) ? '0 : HOUR_W'(hour_at[inst] + 1);
        end else begin
          minute_at[inst] = MIN_W'(minute_at[inst] + 1);
        end
      end else if (r < 92) begin
        hour_at[inst] = (hour_at[inst] >= 23) ? '0 : HOUR_W'(hour_at[inst] + 1);
        if ($urandom_range(0, 1)) minute_at[inst] = MIN_W'($urandom_range(0, 59));
      end else begin
        hour_at[inst] = HOUR_W'($urandom_range(0, 31));
        minute_at[inst] = MIN_W'($urandom_range(0, 63));
      end
      r = $urandom_range(0, 99);
      if (r < 80) price_at[inst] = price_at[inst] + $urandom_range(0, 2000) - 1000;
      else if (r < 90) price_at[inst] = $urandom;
      else if (r < 95) price_at[inst] = 32'h0;
      else price_at[inst] = 32'hFFFF_FFFF;
      send_tick(inst, hour_at[inst], minute_at[inst], price_at[inst]);
    end
    pause(0);

    drain = 0;
    while (book.due_bars.size() != 0 && drain < 5000) begin
      @(posedge clk);
      drain++;
    end
    if (book.due_bars.size() != 0) begin
      $error("%0d bars never arrived", book.due_bars.size());
      book.errors++;
    end
    repeat (20) @(posedge clk);

    $display("ticks accepted: %0d", book.ticks_taken);
    $display("bars checked: %0d minute, %0d hour", book.minute_bars, book.hour_bars);
    if (book.errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  initial begin : watchdog
    #(12 * 300000);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
